/* hw/rtl/csd_pkg.sv */
// Shared types, constants and the compass table builder for the context
// steering direction unit. No dependencies.
package csd_pkg;

    // Fixed field and unit widths
    localparam int OFS_W       = 24;
    localparam int CFG_W       = 23;
    localparam int Q14_W       = 15;
    localparam int STEER_W     = 16;
    localparam int S_DATA_W    = 48;
    localparam int M_DATA_W    = 40;
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;
    localparam int DIV_NUM_W   = 48;
    localparam int DIV_DEN_W   = 32;
    localparam int DIV_Q_W     = 16;
    localparam int SQRT_IN_W   = 64;
    localparam int SQRT_OUT_W  = 32;
    localparam int DIR_COUNT_DEF = 8;

    localparam logic [Q14_W-1:0] ONE_Q14 = 15'd16384;

    // Register reset values
    localparam logic [CFG_W-1:0] FULL_DANGER_RST = 23'd2458;
    localparam logic [CFG_W-1:0] FALLOFF_RST     = 23'd8192;
    localparam logic [CFG_W-1:0] STOPPING_RST    = 23'd0;

    // Register index codes (paddr[3:2])
    localparam logic [1:0] REG_FULL_DANGER = 2'd0;
    localparam logic [1:0] REG_FALLOFF     = 2'd1;
    localparam logic [1:0] REG_STOPPING    = 2'd2;

    typedef struct packed {
        logic [CFG_W-1:0] full_danger_distance;
        logic [CFG_W-1:0] falloff_distance;
        logic [CFG_W-1:0] stopping_distance;
    } csd_cfg_t;

    // Status of an iterative unit
    typedef struct packed {
        logic busy;
        logic done;
    } csd_unit_sts_t;

    // CORDIC rotation table, 2^32 units per turn
    localparam int CORDIC_STEPS = 24;
    localparam longint ATAN_TURN [CORDIC_STEPS] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340247, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81
    };

    // Q1.14 cosine (want_y = 0) or sine (want_y = 1) of a turn angle,
    // evaluated at elaboration to build the compass table.
    function automatic logic signed [STEER_W-1:0] cordic_dir(
        input longint unsigned angle,
        input bit              want_y
    );
        longint z;
        longint x;
        longint y;
        longint dx;
        longint dy;
        longint r;
        bit     flip;
        z    = longint'(angle & 64'hFFFF_FFFF);
        flip = 1'b0;
        x    = 652032874;
        y    = 0;
        if (z >= 64'sh8000_0000) z = z - 64'sh1_0000_0000;
        if (z > (64'sd1 <<< 30)) begin
            z    = z - (64'sd1 <<< 31);
            flip = 1'b1;
        end else if (z < -(64'sd1 <<< 30)) begin
            z    = z + (64'sd1 <<< 31);
            flip = 1'b1;
        end
        for (int k = 0; k < CORDIC_STEPS; k++) begin
            // shifts truncate toward zero
            dx = (x < 0) ? -((-x) >>> k) : (x >>> k);
            dy = (y < 0) ? -((-y) >>> k) : (y >>> k);
            if (z >= 0) begin
                x = x - dy;
                y = y + dx;
                z = z - ATAN_TURN[k];
            end else begin
                x = x + dy;
                y = y - dx;
                z = z + ATAN_TURN[k];
            end
        end
        r = want_y ? y : x;
        r = (r >= 0) ? ((r + 32768) >>> 16) : -((-r + 32768) >>> 16);
        if (flip) r = -r;
        return STEER_W'(r);
    endfunction

endpackage

/* hw/rtl/csd_regs.sv */
// APB configuration registers of the context steering direction unit.
// Depends on csd_pkg.
module csd_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [csd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [csd_pkg::APB_DATA_W-1:0] pwdata,
    output logic [csd_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output csd_pkg::csd_cfg_t              cfg
);
    import csd_pkg::*;

    logic [CFG_W-1:0] full_reg;
    logic [CFG_W-1:0] falloff_reg;
    logic [CFG_W-1:0] stop_reg;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_reg    <= FULL_DANGER_RST;
            falloff_reg <= FALLOFF_RST;
            stop_reg    <= STOPPING_RST;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                REG_FULL_DANGER: full_reg    <= pwdata[CFG_W-1:0];
                REG_FALLOFF:     falloff_reg <= pwdata[CFG_W-1:0];
                REG_STOPPING:    stop_reg    <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (paddr[3:2])
            REG_FULL_DANGER: prdata = APB_DATA_W'(full_reg);
            REG_FALLOFF:     prdata = APB_DATA_W'(falloff_reg);
            REG_STOPPING:    prdata = APB_DATA_W'(stop_reg);
            default:         prdata = '0;
        endcase
    end

    assign cfg.full_danger_distance = full_reg;
    assign cfg.falloff_distance     = falloff_reg;
    assign cfg.stopping_distance    = stop_reg;

endmodule

/* hw/rtl/csd_div.sv */
// Radix-2 restoring divider, one quotient bit per cycle.
// Caller guarantees num < den * 2^DIV_Q_W. Depends on csd_pkg.
module csd_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [csd_pkg::DIV_NUM_W-1:0] num,
    input  logic [csd_pkg::DIV_DEN_W-1:0] den,
    output csd_pkg::csd_unit_sts_t        sts,
    output logic [csd_pkg::DIV_Q_W-1:0]   quot
);
    import csd_pkg::*;

    localparam int CNT_W = $clog2(DIV_Q_W + 1);

    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_Q_W-1:0]   low_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_Q_W-1:0]   quot_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_DEN_W:0]   rem_sh;
    logic                 fits;

    // trial subtract
    assign rem_sh = {rem_reg, low_reg[DIV_Q_W-1]};
    assign fits   = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_Q_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= num[DIV_NUM_W-1:DIV_Q_W];
            low_reg  <= num[DIV_Q_W-1:0];
            den_reg  <= den;
            quot_reg <= '0;
        end else if (busy_reg) begin
            rem_reg  <= fits ? DIV_DEN_W'(rem_sh - {1'b0, den_reg})
                             : rem_sh[DIV_DEN_W-1:0];
            low_reg  <= {low_reg[DIV_Q_W-2:0], 1'b0};
            quot_reg <= {quot_reg[DIV_Q_W-2:0], fits};
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign quot     = quot_reg;

endmodule

/* hw/rtl/csd_sqrt.sv */
// Digit-by-digit integer square root, one root bit per cycle.
// Depends on csd_pkg.
module csd_sqrt (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [csd_pkg::SQRT_IN_W-1:0]  rad,
    output csd_pkg::csd_unit_sts_t         sts,
    output logic [csd_pkg::SQRT_OUT_W-1:0] root
);
    import csd_pkg::*;

    localparam int REM_W = SQRT_OUT_W + 3;
    localparam int CNT_W = $clog2(SQRT_OUT_W + 1);

    logic [SQRT_IN_W-1:0]  rad_reg;
    logic [REM_W-1:0]      rem_reg;
    logic [SQRT_OUT_W-1:0] root_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [REM_W-1:0]      rem_sh;
    logic [REM_W-1:0]      trial;
    logic                  fits;

    // bring down two bits, try root*4+1
    assign rem_sh = {rem_reg[REM_W-3:0], rad_reg[SQRT_IN_W-1 -: 2]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign fits   = rem_sh >= trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(SQRT_OUT_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= rad;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            rad_reg  <= {rad_reg[SQRT_IN_W-3:0], 2'b00};
            rem_reg  <= fits ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[SQRT_OUT_W-2:0], fits};
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign root     = root_reg;

endmodule

/* hw/rtl/context_steering_direction_unit.sv */
// Context steering direction unit, top level.
// Processing time of obstacle and goal words is set by the iterative square
// root and by the divider, which all directions share.
// One word in flight: s_tready is high only while the sequencer is idle.
// Reset (aresetn low, synchronous) clears the danger map and restores registers.
module context_steering_direction_unit #(
    parameter int DIR_COUNT = csd_pkg::DIR_COUNT_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // offset_x [23:0], offset_y [47:24]
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [csd_pkg::S_DATA_W-1:0]   s_tdata,
    // req_type [0]
    input  logic                           s_tuser,
    // steer_x [15:0], steer_y [31:16], arrived [32], zero pad [39:33]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [csd_pkg::M_DATA_W-1:0]   m_tdata,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [csd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [csd_pkg::APB_DATA_W-1:0] pwdata,
    output logic [csd_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import csd_pkg::*;

    localparam int DIR_W = (DIR_COUNT > 1) ? $clog2(DIR_COUNT) : 1;
    localparam int ACC_W = 30 + $clog2(DIR_COUNT);
    localparam int SX_W  = ACC_W - 2;
    localparam int DP_W  = 41;

    // sequencer states
    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_SQX   = 5'd1;
    localparam logic [4:0] S_SQY   = 5'd2;
    localparam logic [4:0] S_DIST  = 5'd3;
    localparam logic [4:0] S_WDIV  = 5'd4;
    localparam logic [4:0] S_DOTX  = 5'd5;
    localparam logic [4:0] S_DOTY  = 5'd6;
    localparam logic [4:0] S_DOTD  = 5'd7;
    localparam logic [4:0] S_SCORE = 5'd8;
    localparam logic [4:0] S_ACCX  = 5'd9;
    localparam logic [4:0] S_ACCY  = 5'd10;
    localparam logic [4:0] S_MAGX  = 5'd11;
    localparam logic [4:0] S_MAGY  = 5'd12;
    localparam logic [4:0] S_MAG   = 5'd13;
    localparam logic [4:0] S_NDX   = 5'd14;
    localparam logic [4:0] S_NDY   = 5'd15;
    localparam logic [4:0] S_OUT   = 5'd16;

    // compass table
    logic signed [STEER_W-1:0] dir_x [DIR_COUNT];
    logic signed [STEER_W-1:0] dir_y [DIR_COUNT];

    for (genvar g = 0; g < DIR_COUNT; g++) begin : g_dir
        localparam longint unsigned ANG =
            (64'd1 << 30) - ((64'(g) << 32) / DIR_COUNT);
        assign dir_x[g] = cordic_dir(ANG, 1'b0);
        assign dir_y[g] = cordic_dir(ANG, 1'b1);
    end

    csd_cfg_t cfg;

    csd_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // shared units
    logic                  div_start;
    logic [DIV_NUM_W-1:0]  div_num;
    logic [DIV_DEN_W-1:0]  div_den;
    csd_unit_sts_t         div_sts;
    logic [DIV_Q_W-1:0]    div_quot;
    logic                  sqrt_start;
    logic [SQRT_IN_W-1:0]  sqrt_rad;
    csd_unit_sts_t         sqrt_sts;
    logic [SQRT_OUT_W-1:0] sqrt_root;

    csd_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .sts     (div_sts),
        .quot    (div_quot)
    );

    csd_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sqrt_start),
        .rad     (sqrt_rad),
        .sts     (sqrt_sts),
        .root    (sqrt_root)
    );

    // state
    logic [4:0]                state_reg, state_next;
    logic signed [OFS_W-1:0]   ox_reg, ox_next;
    logic signed [OFS_W-1:0]   oy_reg, oy_next;
    logic                      goal_reg, goal_next;
    logic [SQRT_IN_W-1:0]      sq_reg, sq_next;
    logic [OFS_W-1:0]          dist_reg, dist_next;
    logic [Q14_W-1:0]          w_reg, w_next;
    logic [DIR_W-1:0]          idx_reg, idx_next;
    logic signed [DP_W-1:0]    dp_reg, dp_next;
    logic                      neg_reg, neg_next;
    logic [Q14_W-1:0]          val_reg, val_next;
    logic signed [ACC_W-1:0]   sx_reg, sx_next;
    logic signed [ACC_W-1:0]   sy_reg, sy_next;
    logic signed [SX_W-1:0]    sxq_reg, sxq_next;
    logic signed [SX_W-1:0]    syq_reg, syq_next;
    logic [SQRT_OUT_W-1:0]     mag_reg, mag_next;
    logic signed [STEER_W-1:0] stx_reg, stx_next;
    logic signed [STEER_W-1:0] sty_reg, sty_next;
    logic                      arr_reg, arr_next;
    logic [Q14_W-1:0]          danger_reg [DIR_COUNT];
    logic [Q14_W-1:0]          danger_next [DIR_COUNT];
    logic                      m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0]       m_data_reg, m_data_next;

    // datapath helpers
    logic signed [2*OFS_W-1:0]         sq_x, sq_y;
    logic [OFS_W-1:0]                  root_d;
    logic signed [OFS_W+STEER_W-1:0]   px, py;
    logic signed [DP_W-1:0]            dsum, dabs;
    logic [DIV_Q_W-1:0]                q_sat;
    logic [Q14_W-1:0]                  dot_pos;
    logic [2*Q14_W-1:0]                score_p;
    logic [Q14_W-1:0]                  score;
    logic signed [STEER_W+Q14_W:0]     ax, ay;
    logic signed [ACC_W-1:0]           sx_adj, sy_adj;
    logic signed [SX_W-1:0]            sxq_c, syq_c, sxq_abs, syq_abs;
    logic signed [2*SX_W-1:0]          sxsq, sysq;
    logic                              last_dir;

    assign sq_x     = ox_reg * ox_reg;
    assign sq_y     = oy_reg * oy_reg;
    assign root_d   = sqrt_root[OFS_W-1:0];
    assign px       = ox_reg * dir_x[idx_reg];
    assign py       = oy_reg * dir_y[idx_reg];
    assign dsum     = dp_reg + DP_W'(py);
    assign dabs     = dsum[DP_W-1] ? -dsum : dsum;
    assign q_sat    = (div_quot > DIV_Q_W'(ONE_Q14)) ? DIV_Q_W'(ONE_Q14) : div_quot;
    assign dot_pos  = neg_reg ? '0 : q_sat[Q14_W-1:0];
    assign score_p  = val_reg * w_reg;
    assign score    = Q14_W'(score_p >> 14);
    assign ax       = dir_x[idx_reg] * $signed({1'b0, val_reg});
    assign ay       = dir_y[idx_reg] * $signed({1'b0, val_reg});
    // divide by four, truncating toward zero
    assign sx_adj   = sx_reg + $signed({{(ACC_W-2){1'b0}}, sx_reg[ACC_W-1], sx_reg[ACC_W-1]});
    assign sy_adj   = sy_reg + $signed({{(ACC_W-2){1'b0}}, sy_reg[ACC_W-1], sy_reg[ACC_W-1]});
    assign sxq_c    = SX_W'(sx_adj >>> 2);
    assign syq_c    = SX_W'(sy_adj >>> 2);
    assign sxq_abs  = sxq_reg[SX_W-1] ? -sxq_reg : sxq_reg;
    assign syq_abs  = syq_reg[SX_W-1] ? -syq_reg : syq_reg;
    assign sxsq     = sxq_c * sxq_c;
    assign sysq     = syq_c * syq_c;
    assign last_dir = (idx_reg == DIR_W'(DIR_COUNT - 1));

    // sequencer
    always_comb begin
        state_next   = state_reg;
        ox_next      = ox_reg;
        oy_next      = oy_reg;
        goal_next    = goal_reg;
        sq_next      = sq_reg;
        dist_next    = dist_reg;
        w_next       = w_reg;
        idx_next     = idx_reg;
        dp_next      = dp_reg;
        neg_next     = neg_reg;
        val_next     = val_reg;
        sx_next      = sx_reg;
        sy_next      = sy_reg;
        sxq_next     = sxq_reg;
        syq_next     = syq_reg;
        mag_next     = mag_reg;
        stx_next     = stx_reg;
        sty_next     = sty_reg;
        arr_next     = arr_reg;
        danger_next  = danger_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        div_start    = 1'b0;
        div_num      = '0;
        div_den      = '0;
        sqrt_start   = 1'b0;
        sqrt_rad     = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    ox_next    = s_tdata[OFS_W-1:0];
                    oy_next    = s_tdata[2*OFS_W-1:OFS_W];
                    goal_next  = s_tuser;
                    state_next = S_SQX;
                end
            end
            S_SQX: begin
                sq_next    = SQRT_IN_W'($unsigned(sq_x));
                state_next = S_SQY;
            end
            S_SQY: begin
                sqrt_start = 1'b1;
                sqrt_rad   = sq_reg + SQRT_IN_W'($unsigned(sq_y));
                state_next = S_DIST;
            end
            S_DIST: begin
                if (sqrt_sts.done) begin
                    dist_next = root_d;
                    arr_next  = root_d <= {1'b0, cfg.stopping_distance};
                    idx_next  = '0;
                    sx_next   = '0;
                    sy_next   = '0;
                    if (goal_reg) begin
                        if (root_d == '0) begin
                            stx_next   = '0;
                            sty_next   = '0;
                            state_next = S_OUT;
                        end else begin
                            state_next = S_DOTX;
                        end
                    end else if (root_d == '0) begin
                        state_next = S_IDLE;
                    end else if (root_d <= {1'b0, cfg.full_danger_distance}) begin
                        w_next     = ONE_Q14;
                        state_next = S_DOTX;
                    end else if (root_d >= {1'b0, cfg.falloff_distance}) begin
                        state_next = S_IDLE;
                    end else begin
                        // weight = (falloff - d) * 2^14 / falloff
                        div_start  = 1'b1;
                        div_num    = DIV_NUM_W'({1'b0, cfg.falloff_distance} - root_d) << 14;
                        div_den    = DIV_DEN_W'(cfg.falloff_distance);
                        state_next = S_WDIV;
                    end
                end
            end
            S_WDIV: begin
                if (div_sts.done) begin
                    w_next     = div_quot[Q14_W-1:0];
                    state_next = S_DOTX;
                end
            end
            S_DOTX: begin
                dp_next    = DP_W'(px);
                state_next = S_DOTY;
            end
            S_DOTY: begin
                neg_next   = dsum[DP_W-1];
                div_start  = 1'b1;
                div_num    = DIV_NUM_W'($unsigned(dabs));
                div_den    = DIV_DEN_W'(dist_reg);
                state_next = S_DOTD;
            end
            S_DOTD: begin
                if (div_sts.done) begin
                    if (goal_reg) begin
                        val_next   = (dot_pos > danger_reg[idx_reg])
                                     ? dot_pos - danger_reg[idx_reg] : '0;
                        state_next = S_ACCX;
                    end else begin
                        val_next   = dot_pos;
                        state_next = S_SCORE;
                    end
                end
            end
            S_SCORE: begin
                if (score > danger_reg[idx_reg]) danger_next[idx_reg] = score;
                if (last_dir) begin
                    state_next = S_IDLE;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_DOTX;
                end
            end
            S_ACCX: begin
                sx_next    = sx_reg + ACC_W'(ax);
                state_next = S_ACCY;
            end
            S_ACCY: begin
                sy_next = sy_reg + ACC_W'(ay);
                if (last_dir) begin
                    state_next = S_MAGX;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_DOTX;
                end
            end
            S_MAGX: begin
                sxq_next   = sxq_c;
                sq_next    = SQRT_IN_W'($unsigned(sxsq));
                state_next = S_MAGY;
            end
            S_MAGY: begin
                syq_next   = syq_c;
                sqrt_start = 1'b1;
                sqrt_rad   = sq_reg + SQRT_IN_W'($unsigned(sysq));
                state_next = S_MAG;
            end
            S_MAG: begin
                if (sqrt_sts.done) begin
                    mag_next = sqrt_root;
                    if (sqrt_root == '0) begin
                        stx_next   = '0;
                        sty_next   = '0;
                        state_next = S_OUT;
                    end else begin
                        div_start  = 1'b1;
                        div_num    = DIV_NUM_W'($unsigned(sxq_abs)) << 14;
                        div_den    = sqrt_root;
                        state_next = S_NDX;
                    end
                end
            end
            S_NDX: begin
                if (div_sts.done) begin
                    stx_next   = sxq_reg[SX_W-1] ? -$signed(div_quot) : $signed(div_quot);
                    div_start  = 1'b1;
                    div_num    = DIV_NUM_W'($unsigned(syq_abs)) << 14;
                    div_den    = mag_reg;
                    state_next = S_NDY;
                end
            end
            S_NDY: begin
                if (div_sts.done) begin
                    sty_next   = syq_reg[SX_W-1] ? -$signed(div_quot) : $signed(div_quot);
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                // hand off to output register, start a new frame
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {7'b0, arr_reg, sty_reg, stx_reg};
                    for (int i = 0; i < DIR_COUNT; i++) danger_next[i] = '0;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            idx_reg     <= '0;
            for (int i = 0; i < DIR_COUNT; i++) danger_reg[i] <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            idx_reg     <= idx_next;
            danger_reg  <= danger_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        ox_reg     <= ox_next;
        oy_reg     <= oy_next;
        goal_reg   <= goal_next;
        sq_reg     <= sq_next;
        dist_reg   <= dist_next;
        w_reg      <= w_next;
        dp_reg     <= dp_next;
        neg_reg    <= neg_next;
        val_reg    <= val_next;
        sx_reg     <= sx_next;
        sy_reg     <= sy_next;
        sxq_reg    <= sxq_next;
        syq_reg    <= syq_next;
        mag_reg    <= mag_next;
        stx_reg    <= stx_next;
        sty_reg    <= sty_next;
        arr_reg    <= arr_next;
        m_data_reg <= m_data_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // checks
    logic danger_any;
    logic danger_over;

    always_comb begin
        danger_any  = 1'b0;
        danger_over = 1'b0;
        for (int i = 0; i < DIR_COUNT; i++) begin
            danger_any  = danger_any || (danger_reg[i] != '0);
            danger_over = danger_over || (danger_reg[i] > ONE_Q14);
        end
    end

    a_idle_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE && !(s_tvalid && s_tready)) |=> state_reg == S_IDLE)
        else $error("sequencer left idle without an accepted word");

    a_frame_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT && state_next == S_IDLE) |=> !danger_any)
        else $error("danger map not cleared after goal word");

    a_danger_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        !danger_over)
        else $error("danger level above one");

    a_div_free: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_sts.busy)
        else $error("divider started while busy");

    a_sqrt_free: assert property (@(posedge aclk) disable iff (!aresetn)
        sqrt_start |-> !sqrt_sts.busy)
        else $error("square root started while busy");

endmodule

/* sim/tb_context_steering_direction_unit.sv */
// Testbench for context_steering_direction_unit: obstacle/goal frames over the
// stream ports, checked against an in-bench danger/steering predictor.
// Depends on csd_pkg and the unit's RTL only.
module tb_context_steering_direction_unit;
    import csd_pkg::*;

    localparam int NDIR = DIR_COUNT_DEF;
    localparam bit KIND_OBST = 1'b0;
    localparam bit KIND_GOAL = 1'b1;
    localparam int DRAIN_CYCLES = 400;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;   // offset_x [23:0], offset_y [47:24]
    logic                  s_tuser;   // req_type [0]
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;   // steer_x [15:0], steer_y [31:16], arrived [32]
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    context_steering_direction_unit DUT (.*);

    typedef struct {
        logic signed [STEER_W-1:0] sx;
        logic signed [STEER_W-1:0] sy;
        logic                      arrived;
    } steer_t;

    typedef struct {
        bit     kind;
        int     ox;
        int     oy;
        bit     known;
        steer_t want;
    } row_t;

    // predictor state
    longint compass_x [NDIR];
    longint compass_y [NDIR];
    longint danger [NDIR];
    longint full_dist, fall_dist, stop_dist;
    steer_t pending_steer [$];
    bit     failed;
    bit     calm;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #40000000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic longint unsigned root64(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // compass unit vector by 24-step rotation, Q1.14 rounded to nearest
    function automatic void rotate_unit(longint unsigned ang, output longint c,
                                        output longint s);
        longint z, x, y, dx, dy, p;
        bit flip;
        z = longint'(ang & 64'hFFFF_FFFF);
        x = 652032874;
        y = 0;
        flip = 0;
        if (z >= (64'sd1 <<< 31)) z -= (64'sd1 <<< 32);
        if (z > (64'sd1 <<< 30)) begin
            z -= (64'sd1 <<< 31);
            flip = 1;
        end else if (z < -(64'sd1 <<< 30)) begin
            z += (64'sd1 <<< 31);
            flip = 1;
        end
        for (int k = 0; k < CORDIC_STEPS; k++) begin
            p = 64'sd1 <<< k;
            dx = x / p;
            dy = y / p;
            if (z >= 0) begin
                x -= dy; y += dx; z -= ATAN_TURN[k];
            end else begin
                x += dy; y -= dx; z += ATAN_TURN[k];
            end
        end
        x = (x >= 0 ? x + 32768 : x - 32768) / 65536;
        y = (y >= 0 ? y + 32768 : y - 32768) / 65536;
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic longint heading_dot(longint ox, longint oy, longint d, int i);
        longint q;
        q = (ox * compass_x[i] + oy * compass_y[i]) / d;
        if (q > 16384) q = 16384;
        if (q < -16384) q = -16384;
        return q;
    endfunction

    // update danger map; returns 1 with the steering word for goal words
    function automatic bit steer_predict(bit kind, longint ox, longint oy,
                                         output steer_t res);
        longint d, w, sc, sx, sy, mag, v;
        d = longint'(root64(longint'(ox * ox) + longint'(oy * oy)));
        res = '{0, 0, 0};
        if (kind == KIND_OBST) begin
            if (d == 0) return 0;
            if (d <= full_dist) w = 16384;
            else if (d >= fall_dist) w = 0;
            else w = (fall_dist - d) * 16384 / fall_dist;
            for (int i = 0; i < NDIR; i++) begin
                sc = heading_dot(ox, oy, d, i) * w / 16384;
                if (sc > 16384) sc = 16384;
                if (sc > danger[i]) danger[i] = sc;
            end
            return 0;
        end
        sx = 0;
        sy = 0;
        for (int i = 0; i < NDIR; i++) begin
            v = 0;
            if (d != 0) begin
                v = heading_dot(ox, oy, d, i);
                if (v < 0) v = 0;
            end
            v -= danger[i];
            if (v < 0) v = 0;
            sx += compass_x[i] * v;
            sy += compass_y[i] * v;
            danger[i] = 0;
        end
        sx /= 4;
        sy /= 4;
        mag = longint'(root64(longint'(sx * sx) + longint'(sy * sy)));
        if (mag != 0) begin
            res.sx = STEER_W'(sx * 16384 / mag);
            res.sy = STEER_W'(sy * 16384 / mag);
        end
        res.arrived = (d <= stop_dist);
        return 1;
    endfunction

    // APB write: setup then access, register taken at the access edge
    task automatic reg_write(logic [1:0] idx, int unsigned val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_FULL_DANGER: full_dist = val & 32'h7F_FFFF;
            REG_FALLOFF:     fall_dist = val & 32'h7F_FFFF;
            default:         stop_dist = val & 32'h7F_FFFF;
        endcase
    endtask

    // send one word; known rows carry a typed-in expectation
    task automatic send_word(bit kind, int ox, int oy, bit known, steer_t want);
        steer_t res;
        int gap;
        gap = (!calm && $urandom_range(0, 99) < 16) ? $urandom_range(1, 6) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {oy[23:0], ox[23:0]};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (steer_predict(kind, ox, oy, res)) pending_steer.push_back(known ? want : res);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_steer.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic int pick_offset();
        longint lim;
        if ($urandom_range(0, 3) == 0) return int'({{8{1'b0}}, 24'($urandom)}) << 8 >>> 8;
        lim = 2 * fall_dist + 16;
        if (lim > 8388607) lim = 8388607;
        return int'(longint'($urandom_range(0, 2 * lim)) - lim);
    endfunction

    // result side: random stalls, in-order compare
    always @(posedge aclk) begin
        steer_t exp_s;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_steer.size() == 0) begin
                    $display("%0t: unexpected word %h", $time, m_tdata);
                    failed = 1;
                end else begin
                    exp_s = pending_steer.pop_front();
                    if (m_tdata[15:0] !== exp_s.sx) begin
                        $display("%0t: steer_x exp %0d got %0d", $time, exp_s.sx,
                                 $signed(m_tdata[15:0]));
                        failed = 1;
                    end
                    if (m_tdata[31:16] !== exp_s.sy) begin
                        $display("%0t: steer_y exp %0d got %0d", $time, exp_s.sy,
                                 $signed(m_tdata[31:16]));
                        failed = 1;
                    end
                    if (m_tdata[32] !== exp_s.arrived) begin
                        $display("%0t: arrived exp %0b got %0b", $time, exp_s.arrived,
                                 m_tdata[32]);
                        failed = 1;
                    end
                end
            end
            m_tready <= calm || ($urandom_range(0, 99) >= 16);
        end
    end

    // directed frames: reset state, extremes, saturation, distance edges
    row_t dir_rows [] = '{
        '{KIND_GOAL, 0, 0, 1, '{16'sd0, 16'sd0, 1'b1}},
        '{KIND_GOAL, 0, 4096, 1, '{16'sd0, 16'sd16384, 1'b0}},
        '{KIND_GOAL, 4096, 0, 1, '{16'sd16384, 16'sd0, 1'b0}},
        '{KIND_OBST, 0, 0, 0, '{0, 0, 0}},
        '{KIND_OBST, 2458, 0, 0, '{0, 0, 0}},
        '{KIND_OBST, 0, 9000, 0, '{0, 0, 0}},
        '{KIND_GOAL, 4096, 4096, 0, '{0, 0, 0}},
        '{KIND_OBST, 0, 1000, 0, '{0, 0, 0}},
        '{KIND_OBST, 0, 2000, 0, '{0, 0, 0}},
        '{KIND_OBST, -5000, 3000, 0, '{0, 0, 0}},
        '{KIND_GOAL, 0, 4096, 0, '{0, 0, 0}},
        '{KIND_OBST, -8388608, -8388608, 0, '{0, 0, 0}},
        '{KIND_OBST, 8388607, 8388607, 0, '{0, 0, 0}},
        '{KIND_GOAL, -8388608, 8388607, 0, '{0, 0, 0}},
        '{KIND_OBST, 100, -3, 0, '{0, 0, 0}},
        '{KIND_GOAL, 8388607, -8388608, 0, '{0, 0, 0}},
        '{KIND_OBST, -4000, -4000, 0, '{0, 0, 0}},
        '{KIND_GOAL, 1, 0, 0, '{0, 0, 0}}
    };

    // register settings per phase: full danger, falloff, stopping
    int unsigned phase_cfg [6][3] = '{
        '{0, 1, 0},
        '{8388607, 8388607, 8388607},
        '{0, 8388607, 4096},
        '{4096, 0, 0},
        '{1000, 20000, 3000},
        '{2458, 8192, 0}
    };

    initial begin
        longint c, s;
        int nobs;
        steer_t none;
        none = '{0, 0, 0};
        failed = 0;
        calm = 0;
        for (int i = 0; i < NDIR; i++) begin
            rotate_unit((64'd1 << 30) - ((longint'(i) << 32) / NDIR), c, s);
            compass_x[i] = c;
            compass_y[i] = s;
            danger[i] = 0;
        end
        full_dist = FULL_DANGER_RST;
        fall_dist = FALLOFF_RST;
        stop_dist = STOPPING_RST;
        aresetn <= 1'b0;
        s_tvalid <= 1'b0; s_tuser <= 1'b0; s_tdata <= '0;
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[r])
            send_word(dir_rows[r].kind, dir_rows[r].ox, dir_rows[r].oy,
                      dir_rows[r].known, dir_rows[r].want);
        settle();

        for (int ph = 0; ph < 8; ph++) begin
            if (ph < 6) begin
                reg_write(REG_FULL_DANGER, phase_cfg[ph][0]);
                reg_write(REG_FALLOFF, phase_cfg[ph][1]);
                reg_write(REG_STOPPING, phase_cfg[ph][2]);
            end else begin
                reg_write(REG_FULL_DANGER, $urandom);
                reg_write(REG_FALLOFF, $urandom);
                reg_write(REG_STOPPING, $urandom_range(0, 40000));
            end
            calm = (ph == 4);
            // mostly well-formed frames, some bare goals and stray kinds
            for (int f = 0; f < 45; f++) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_word(1'($urandom), pick_offset(), pick_offset(), 0, none);
                end else begin
                    nobs = $urandom_range(0, 4);
                    repeat (nobs) send_word(KIND_OBST, pick_offset(), pick_offset(), 0, none);
                    send_word(KIND_GOAL, pick_offset(), pick_offset(), 0, none);
                end
            end
            settle();
        end
        calm = 0;

        if (!failed) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/csd_pkg.sv
hw/rtl/csd_regs.sv
hw/rtl/csd_div.sv
hw/rtl/csd_sqrt.sv
hw/rtl/context_steering_direction_unit.sv
sim/tb_context_steering_direction_unit.sv
